@@ rtl/krt_pkg.sv @@
// shared types and status codes of the keyed record table
package krt_pkg;

   typedef enum logic [1:0] {
      STATUS_DONE      = 2'd0,
      STATUS_DUPLICATE = 2'd1,
      STATUS_NOT_FOUND = 2'd2,
      STATUS_FULL      = 2'd3
   } status_type;

   typedef enum logic {
      KIND_ADD    = 1'b0,
      KIND_DELETE = 1'b1
   } kind_type;

   typedef struct packed {
      logic [15:0] grade;
      logic [15:0] credits;
      logic [31:0] key;
   } record_type;

endpackage

@@ rtl/keyed_record_table.sv @@
// keyed record table: unsorted array in one memory, linear search, swap delete
//
//  channel | dir | tdata (lsb up)                      | tuser (lsb up)
//  --------+-----+-------------------------------------+----------------
//  req     | in  | key[31:0] credits[47:32] grade[63:48] | kind[0]
//  rsp     | out | entry_count[6:0] slot[12:7] zero pad   | status[1:0]
//
//  a word is accepted only in the idle state, once the previous item has been answered.
//  the search reads one stored key per cycle through the single read port of the
//  record memory and stops early on a hit; a delete hit then reads the last record
//  and moves it into the vacated slot in the move state.
//  reset clears the state, the entry count and the pending and rsp valid flags; the memory is never cleared.
//  a new word is taken while an earlier result still waits on rsp; the next result
//  then holds in its reply state and keeps req off until rsp drains.
module keyed_record_table #(
   parameter int TABLE_ENTRIES = 64
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [63:0] req_tdata,   // key, credits, grade
   input  logic [0:0]  req_tuser,   // kind
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata,   // entry_count, slot, zero pad
   output logic [1:0]  rsp_tuser    // status
);

   localparam int AW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
   localparam int CW = $clog2(TABLE_ENTRIES + 1);

   typedef enum logic [2:0] {
      IDLE,
      SCAN,
      MOVE,
      REPLY
   } state_type;

   krt_pkg::record_type mem_ff [TABLE_ENTRIES];
   krt_pkg::record_type rd_data_ff;
   krt_pkg::record_type wr_data;
   krt_pkg::record_type item_ff, item_in;
   logic [AW-1:0]       rd_addr, wr_addr;
   logic                wr_en;

   state_type           state_ff, state_in;
   krt_pkg::kind_type   kind_ff, kind_in;
   logic [CW-1:0]       idx_ff, idx_in;
   logic [CW-1:0]       count_ff, count_in;
   logic [CW-1:0]       count_dec;
   logic                pend_ff, pend_in;
   logic [AW-1:0]       pend_idx_ff, pend_idx_in;
   logic [AW-1:0]       hit_ff, hit_in;
   krt_pkg::status_type res_status_ff, res_status_in;
   logic [AW-1:0]       res_slot_ff, res_slot_in;
   logic                rsp_valid_ff, rsp_valid_in;
   krt_pkg::status_type rsp_status_ff, rsp_status_in;
   logic [6:0]          rsp_count_ff, rsp_count_in;
   logic [5:0]          rsp_slot_ff, rsp_slot_in;
   logic                hit_now;

   assign req_tready = (state_ff == IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {3'b000, rsp_slot_ff, rsp_count_ff};
   assign rsp_tuser  = rsp_status_ff;

   assign count_dec = count_ff - CW'(1);
   assign hit_now   = pend_ff && (rd_data_ff.key == item_ff.key);

   always_comb begin
      state_in      = state_ff;
      kind_in       = kind_ff;
      item_in       = item_ff;
      idx_in        = idx_ff;
      count_in      = count_ff;
      pend_in       = 1'b0;
      pend_idx_in   = idx_ff[AW-1:0];
      hit_in        = hit_ff;
      res_status_in = res_status_ff;
      res_slot_in   = res_slot_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      rsp_status_in = rsp_status_ff;
      rsp_count_in  = rsp_count_ff;
      rsp_slot_in   = rsp_slot_ff;
      rd_addr       = idx_ff[AW-1:0];
      wr_en         = 1'b0;
      wr_addr       = hit_ff;
      wr_data       = rd_data_ff;
      case (state_ff)
         IDLE: begin
            if (req_tvalid) begin
               kind_in       = krt_pkg::kind_type'(req_tuser[0]);
               item_in.key     = req_tdata[31:0];
               item_in.credits = req_tdata[47:32];
               item_in.grade   = req_tdata[63:48];
               idx_in        = '0;
               state_in      = SCAN;
            end
         end
         SCAN: begin
            if (hit_now) begin
               hit_in = pend_idx_ff;
               if (kind_ff == krt_pkg::KIND_ADD) begin
                  res_status_in = krt_pkg::STATUS_DUPLICATE;
                  res_slot_in   = '0;
                  state_in      = REPLY;
               end else begin
                  // fetch the last record to fill the vacated slot
                  rd_addr  = count_dec[AW-1:0];
                  state_in = MOVE;
               end
            end else if (!pend_ff && (idx_ff == count_ff)) begin
               res_slot_in = '0;
               state_in    = REPLY;
               if (kind_ff == krt_pkg::KIND_DELETE) begin
                  res_status_in = krt_pkg::STATUS_NOT_FOUND;
               end else if (count_ff == CW'(TABLE_ENTRIES)) begin
                  res_status_in = krt_pkg::STATUS_FULL;
               end else begin
                  wr_en         = 1'b1;
                  wr_addr       = count_ff[AW-1:0];
                  wr_data       = item_ff;
                  res_status_in = krt_pkg::STATUS_DONE;
                  res_slot_in   = count_ff[AW-1:0];
                  count_in      = count_ff + CW'(1);
               end
            end else if (idx_ff != count_ff) begin
               pend_in = 1'b1;
               idx_in  = idx_ff + CW'(1);
            end
         end
         MOVE: begin
            wr_en         = 1'b1;
            wr_addr       = hit_ff;
            wr_data       = rd_data_ff;
            count_in      = count_dec;
            res_status_in = krt_pkg::STATUS_DONE;
            res_slot_in   = hit_ff;
            state_in      = REPLY;
         end
         REPLY: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = res_status_ff;
               rsp_count_in  = 7'(count_ff);
               rsp_slot_in   = 6'(res_slot_ff);
               state_in      = IDLE;
            end
         end
         default: begin
            state_in = IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      kind_in_reg: begin
         kind_ff       <= kind_in;
         item_ff       <= item_in;
         idx_ff        <= idx_in;
         pend_idx_ff   <= pend_idx_in;
         hit_ff        <= hit_in;
         res_status_ff <= res_status_in;
         res_slot_ff   <= res_slot_in;
         rsp_status_ff <= rsp_status_in;
         rsp_count_ff  <= rsp_count_in;
         rsp_slot_ff   <= rsp_slot_in;
      end
      if (reset) begin
         state_ff     <= IDLE;
         count_ff     <= '0;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // record memory, one write and one registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(TABLE_ENTRIES))
      else $error("entry count above table size");

   a_accept_starts_scan: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> (state_ff == SCAN && idx_ff == '0 && !pend_ff))
      else $error("accepted word did not start a search");

   a_count_moves_on_write: assert property (@(posedge clock) disable iff (reset)
      (count_ff != $past(count_ff)) |-> $past(wr_en))
      else $error("entry count changed without a memory write");

   a_error_slot_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_status_ff != krt_pkg::STATUS_DONE) |-> (rsp_slot_ff == '0))
      else $error("slot nonzero on a failed operation");

   a_write_only_when_busy: assert property (@(posedge clock) disable iff (reset)
      wr_en |-> (state_ff == SCAN || state_ff == MOVE))
      else $error("memory written outside search or move");

endmodule
